/* sv/bsc_pkg.sv */
// Shared constants, types and row helpers for the backward search counter.
// No dependencies; imported by bsc_ram users and bwt_backward_search_count.
package bsc_pkg;

  localparam int unsigned MAX_LEN   = 4096;
  localparam int unsigned ALPHABET  = 5;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned SYM_W     = 3;
  localparam int unsigned ROW_DEPTH = MAX_LEN + 1;
  localparam int unsigned ADDR_W    = $clog2(ROW_DEPTH);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PATTERN = 1'b1;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SYM_W-1:0]  sym_t;

  // One row of the occurrence table: a count for each symbol of the alphabet.
  typedef logic [ALPHABET-1:0][CNT_W-1:0] row_t;

  function automatic cnt_t row_get(row_t row, sym_t sym);
    cnt_t v;
    v = '0;
    for (int c = 0; c < ALPHABET; c++) begin
      if (sym == SYM_W'(c)) begin
        v = row[c];
      end
    end
    return v;
  endfunction

  function automatic row_t row_inc(row_t row, sym_t sym);
    row_t r;
    r = row;
    for (int c = 0; c < ALPHABET; c++) begin
      if (sym == SYM_W'(c)) begin
        r[c] = row[c] + CNT_W'(1);
      end
    end
    return r;
  endfunction

  // Exclusive prefix sums of the symbol totals give the first sorted row of each symbol.
  function automatic row_t row_starts(row_t totals);
    row_t s;
    cnt_t acc;
    acc = '0;
    for (int c = 0; c < ALPHABET; c++) begin
      s[c] = acc;
      acc  = acc + totals[c];
    end
    return s;
  endfunction

endpackage

/* sv/bwt_backward_search_count.sv */
// FM-index backward search counter, top level.
// Depends on bsc_pkg and on bsc_ram for the occurrence table.
//
// Usage: one input channel carries operation, symbol and last; a load transfer
// appends one Burrows-Wheeler text symbol, a pattern transfer feeds one
// pattern symbol, last character first. The output channel carries
// match_count once per pattern, after the transfer that has last set.
// A load transfer writes the next occurrence row into the table memory
// while the newest row stays in a register. The reads of a pattern symbol
// are serialised by the single read port of the table memory: the top row
// is read in the accept cycle, the row below the bottom in S_RD_BOT, and the
// interval is updated in S_UPDATE. A symbol that is absent, or one that
// arrives after the interval has emptied, skips the table reads. The count
// is on the output in the cycle after the last symbol's update.
// Reset clears the text length, totals and pattern state at once; the table
// memory needs no clearing pass, since only rows already written are read
// and row zero always reads as zero. The input stalls while a symbol is in
// flight, and also while a finished count waits on a stalled receiver.
module bwt_backward_search_count (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  bsc_pkg::sym_t       symbol_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsc_pkg::cnt_t       match_count_o
);
  import bsc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_BOT,
    S_UPDATE
  } state_e;

  state_e state_q, state_d;

  // Text state: the newest occurrence row doubles as the symbol totals.
  addr_t len_q, len_d;
  row_t  cur_row_q, cur_row_d;
  row_t  starts_q, starts_d;
  logic  load_open_q, load_open_d;

  // Pattern state.
  addr_t top_q, top_d;
  addr_t bot_q, bot_d;
  logic  pattern_open_q, pattern_open_d;
  logic  dead_q, dead_d;
  sym_t  sym_q, sym_d;
  logic  last_q, last_d;
  cnt_t  lo_q, lo_d;
  logic  rzero_q, rzero_d;

  // Result register.
  logic  out_valid_q, out_valid_d;
  cnt_t  count_q, count_d;

  // Table memory port.
  logic  ram_we;
  addr_t ram_waddr;
  row_t  ram_wdata;
  addr_t ram_raddr;
  row_t  ram_rdata;

  logic  in_fire;
  logic  out_take;
  logic  res_fire;
  cnt_t  res_cnt;
  addr_t start_len;
  row_t  start_row;
  logic  pat_new;
  addr_t eff_top;
  addr_t eff_bot;
  logic  eff_dead;
  logic  sym_ok;
  logic  absent;
  cnt_t  rd_count;
  cnt_t  sym_start;

  bsc_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(ROW_DEPTH)
  ) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o    = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire       = in_valid_i && !in_stall_o;
  assign out_take      = out_valid_q && !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign match_count_o = count_q;

  // A load that opens a new text starts from an empty row zero.
  assign start_len = load_open_q ? len_q : '0;
  assign start_row = load_open_q ? cur_row_q : '0;

  // The first symbol of a pattern opens the full interval over the text.
  assign pat_new  = !pattern_open_q;
  assign eff_top  = pat_new ? '0 : top_q;
  assign eff_bot  = pat_new ? (len_q - ADDR_W'(1)) : bot_q;
  assign eff_dead = pat_new ? (len_q == '0) : dead_q;
  assign sym_ok   = (symbol_i < SYM_W'(ALPHABET));
  assign absent   = !sym_ok || (row_get(cur_row_q, symbol_i) == '0);

  // Row zero is never written after reset; it always reads as zero.
  assign rd_count  = rzero_q ? '0 : row_get(ram_rdata, sym_q);
  assign sym_start = row_get(starts_q, sym_q);

  always_comb begin
    state_d        = state_q;
    len_d          = len_q;
    cur_row_d      = cur_row_q;
    starts_d       = row_starts(cur_row_q);
    load_open_d    = load_open_q;
    top_d          = top_q;
    bot_d          = bot_q;
    pattern_open_d = pattern_open_q;
    dead_d         = dead_q;
    sym_d          = sym_q;
    last_d         = last_q;
    lo_d           = lo_q;
    ram_we         = 1'b0;
    ram_waddr      = start_len + ADDR_W'(1);
    ram_wdata      = row_inc(start_row, symbol_i);
    ram_raddr      = bot_q + ADDR_W'(1);
    res_fire       = 1'b0;
    res_cnt        = '0;

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = eff_top;
        if (in_fire) begin
          if (operation_i == OP_LOAD) begin
            pattern_open_d = 1'b0;
            load_open_d    = !last_i;
            len_d          = start_len;
            cur_row_d      = start_row;
            if ((start_len < ADDR_W'(MAX_LEN)) && sym_ok) begin
              ram_we    = 1'b1;
              cur_row_d = ram_wdata;
              len_d     = start_len + ADDR_W'(1);
            end
          end else begin
            pattern_open_d = 1'b1;
            top_d          = eff_top;
            bot_d          = eff_bot;
            sym_d          = symbol_i;
            last_d         = last_i;
            if (eff_dead || absent) begin
              // Nothing left to narrow: skip the table reads.
              dead_d = 1'b1;
              if (last_i) begin
                res_fire       = 1'b1;
                pattern_open_d = 1'b0;
              end
            end else begin
              dead_d  = 1'b0;
              state_d = S_RD_BOT;
            end
          end
        end
      end
      S_RD_BOT: begin
        lo_d    = rd_count;
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        // A last symbol waits while the result register holds a stalled count.
        if (!(last_q && out_valid_q && out_stall_i)) begin
          state_d = S_IDLE;
          if (rd_count <= lo_q) begin
            dead_d = 1'b1;
          end else begin
            top_d   = ADDR_W'(sym_start + lo_q);
            bot_d   = ADDR_W'(sym_start + rd_count - CNT_W'(1));
            res_cnt = rd_count - lo_q;
          end
          if (last_q) begin
            res_fire       = 1'b1;
            pattern_open_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rzero_d = (ram_raddr == '0);

    if (res_fire) begin
      out_valid_d = 1'b1;
      count_d     = res_cnt;
    end else begin
      out_valid_d = out_valid_q && !out_take;
      count_d     = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      len_q          <= '0;
      cur_row_q      <= '0;
      starts_q       <= '0;
      load_open_q    <= 1'b0;
      top_q          <= '0;
      bot_q          <= '0;
      pattern_open_q <= 1'b0;
      dead_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      count_q        <= '0;
    end else begin
      state_q        <= state_d;
      len_q          <= len_d;
      cur_row_q      <= cur_row_d;
      starts_q       <= starts_d;
      load_open_q    <= load_open_d;
      top_q          <= top_d;
      bot_q          <= bot_d;
      pattern_open_q <= pattern_open_d;
      dead_q         <= dead_d;
      out_valid_q    <= out_valid_d;
      count_q        <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q   <= sym_d;
    last_q  <= last_d;
    lo_q    <= lo_d;
    rzero_q <= rzero_d;
  end

`ifndef SYNTHESIS
  // Table writes only come from a load taken in the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE) && in_fire)
    else $error("occurrence table written outside a load transfer");

  // A live interval is never empty and never reaches past the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pattern_open_q && !dead_q) |-> (top_q <= bot_q) && (bot_q < len_q))
    else $error("search interval out of range");

  // A new count is never produced over one the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_fire && out_valid_q) |-> !out_stall_i)
    else $error("result register overwritten");

  // The text never grows beyond the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= ADDR_W'(MAX_LEN))
    else $error("text length beyond table depth");
`endif

endmodule

/* sv/bsc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
